FILE: src/ols_pkg.sv
// ----------------------------------------------------------------------------
// ols_pkg
// Shared types and codes for the ordered list store and its cells.
// ----------------------------------------------------------------------------
package ols_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 7;

  localparam logic [2:0] OP_READOUT    = 3'd0;
  localparam logic [2:0] OP_INS_FRONT  = 3'd1;
  localparam logic [2:0] OP_INS_END    = 3'd2;
  localparam logic [2:0] OP_INS_POS    = 3'd3;
  localparam logic [2:0] OP_DEL_FIRST  = 3'd4;
  localparam logic [2:0] OP_DEL_LAST   = 3'd5;
  localparam logic [2:0] OP_DEL_POS    = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // What every cell of the chain does.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_t;

  // Broadcast control: idx is the target entry for inserts and deletes,
  // and the tail entry for a rotation.
  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] idx;
  } cell_ctrl_t;

endpackage

FILE: src/ols_cell.sv
// ----------------------------------------------------------------------------
// ols_cell
// One entry of the list chain, shifting towards either neighbour on command.
// ----------------------------------------------------------------------------
module ols_cell
  import ols_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic signed [VAL_W-1:0] left_val,
  input  logic signed [VAL_W-1:0] right_val,
  input  logic signed [VAL_W-1:0] head_val,
  input  logic signed [VAL_W-1:0] new_val,
  output logic signed [VAL_W-1:0] val
);

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

  logic signed [VAL_W-1:0] val_next;

  always_comb begin
    val_next = val;
    case (ctrl.op)
      CELL_INS: begin
        if (MY_IDX > ctrl.idx) val_next = left_val;
        else if (MY_IDX == ctrl.idx) val_next = new_val;
      end
      CELL_DEL: begin
        if (MY_IDX >= ctrl.idx) val_next = right_val;
      end
      CELL_ROT: begin
        // The tail entry wraps round to take the head.
        if (MY_IDX == ctrl.idx) val_next = head_val;
        else if (MY_IDX < ctrl.idx) val_next = right_val;
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

FILE: src/ordered_list_store.sv
// ----------------------------------------------------------------------------
// ordered_list_store
// Bounded ordered list of signed 32-bit values held in a chain of cells.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                     Handshake
// --------  ------------------------------------------  ---------------------
// command   opcode, position, value                     start && !busy
// result    value_out, status, last, entry_count        strobe (one cycle)
//
// An insert or delete shifts every cell towards its neighbour at the clock
// edge that accepts it, and the status beat appears in the following cycle.
// A readout of n entries gives n beats (one if the list is empty); the chain
// rotates by one entry per cycle so that the head cell always holds the next
// entry, and after n rotations the list is back in its original order.
// Reset empties the list at once; cell contents are left as they are.
// The receiver cannot stall: each result beat is valid for one cycle only.
// ----------------------------------------------------------------------------
module ordered_list_store
  import ols_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              opcode,
  input  logic [POS_W-1:0]        position,
  input  logic signed [VAL_W-1:0] value,
  output logic                    strobe,
  output logic signed [VAL_W-1:0] value_out,
  output logic [1:0]              status,
  output logic                    last,
  output logic [POS_W-1:0]        entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t          state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] rd_idx, rd_idx_next;

  logic signed [VAL_W-1:0] cell_val [CAPACITY];
  cell_ctrl_t              ctrl;

  logic                    accept;
  logic [POS_W:0]          count_w;
  logic                    res_valid;
  logic signed [VAL_W-1:0] res_value;
  logic [1:0]              res_status;
  logic                    res_last;

  assign accept  = start && (state == S_IDLE);
  assign busy    = (state == S_READ);
  assign count_w = (POS_W + 1)'(count);

  // Decode the command, check it against the fill level and tell the chain
  // what to do. A readout rotates the chain and emits the head cell.
  always_comb begin
    state_next  = state;
    count_next  = count;
    rd_idx_next = rd_idx;
    ctrl.op     = CELL_HOLD;
    ctrl.idx    = '0;
    res_valid   = 1'b0;
    res_value   = '0;
    res_status  = ST_OK;
    res_last    = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_valid = 1'b1;
          unique case (opcode) inside
            OP_READOUT: begin
              if (count == '0) begin
                res_status = ST_EMPTY;
              end else begin
                res_value = cell_val[0];
                res_last  = (count == CNT_W'(1));
                ctrl.op   = CELL_ROT;
                ctrl.idx  = POS_W'(count_w - 1'b1);
                if (count != CNT_W'(1)) begin
                  state_next  = S_READ;
                  rd_idx_next = CNT_W'(1);
                end
              end
            end
            OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
              if (count == CAP_CNT) begin
                res_status = ST_FULL;
              end else if (opcode == OP_INS_POS &&
                           ((position == '0) ||
                            ((POS_W + 1)'(position) > count_w + 1'b1))) begin
                res_status = ST_RANGE;
              end else begin
                ctrl.op    = CELL_INS;
                count_next = count + 1'b1;
                if (opcode == OP_INS_FRONT) ctrl.idx = '0;
                else if (opcode == OP_INS_END) ctrl.idx = POS_W'(count_w);
                else ctrl.idx = position - 1'b1;
              end
            end
            OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_POS: begin
              if (count == '0) begin
                res_status = ST_EMPTY;
              end else if (opcode == OP_DEL_POS &&
                           ((position == '0) ||
                            ((POS_W + 1)'(position) > count_w))) begin
                res_status = ST_RANGE;
              end else begin
                ctrl.op    = CELL_DEL;
                count_next = count - 1'b1;
                if (opcode == OP_DEL_FIRST) ctrl.idx = '0;
                else if (opcode == OP_DEL_LAST) ctrl.idx = POS_W'(count_w - 1'b1);
                else ctrl.idx = position - 1'b1;
              end
            end
            default: begin
              // The unused opcode leaves the list alone and reports success.
              res_status = ST_OK;
            end
          endcase
        end
      end
      S_READ: begin
        res_valid   = 1'b1;
        res_value   = cell_val[0];
        res_last    = ((POS_W + 1)'(rd_idx) + 1'b1 == count_w);
        ctrl.op     = CELL_ROT;
        ctrl.idx    = POS_W'(count_w - 1'b1);
        rd_idx_next = rd_idx + 1'b1;
        if (res_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // The chain itself: each cell sees its neighbours, the head and the new value.
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;

    if (gi == 0) begin : g_first
      assign left_v = value;
    end else begin : g_mid_l
      assign left_v = cell_val[gi-1];
    end

    if (gi == CAPACITY - 1) begin : g_end
      assign right_v = cell_val[gi];
    end else begin : g_mid_r
      assign right_v = cell_val[gi+1];
    end

    ols_cell #(
      .INDEX(gi)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .left_val (left_v),
      .right_val(right_v),
      .head_val (cell_val[0]),
      .new_val  (value),
      .val      (cell_val[gi])
    );
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      rd_idx <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rd_idx <= rd_idx_next;
      strobe <= res_valid;
    end
  end

  // Result payload, registered so the beat lines up with the strobe.
  always_ff @(posedge clk) begin
    value_out   <= res_value;
    status      <= res_status;
    last        <= res_last;
    entry_count <= POS_W'(count_next);
  end

`ifndef SYNTHESIS
  // The fill level never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("entry count above capacity");

  // A readout in progress always has entries left to send.
  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (rd_idx < count) && (count != '0))
    else $error("readout index past the list end");

  // Every result beat follows an accepted command or a readout cycle.
  a_strobe_cause: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && strobe) |-> ($past(accept) || $past(state == S_READ)))
    else $error("result beat without cause");

  // A readout leaves the fill level unchanged.
  a_read_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> $stable(count))
    else $error("entry count changed during readout");
`endif

endmodule

FILE: tb/sv/ordered_list_store_test.sv
// ----------------------------------------------------------------------------
// ordered_list_store_test
// Self-checking testbench for the ordered list store. A mirror of the list
// predicts every result beat from each accepted command. A monitor compares
// every strobed beat, field by field, with the oldest prediction. Stimulus is
// a short directed sequence followed by random commands. The random commands
// are grouped into fill, drain and mixed stretches so that the list reaches
// both the empty and the full state many times.
// ----------------------------------------------------------------------------
module ordered_list_store_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ols_pkg::*;

  localparam int CAPACITY = 32;

  // The package has no name for the spare opcode. The block ignores it and
  // answers with a plain ok status.
  localparam logic [2:0] OP_SPARE = 3'd7;

  localparam int RANDOM_ITEMS = 360;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  // One result beat as the block presents it.
  typedef struct {
    logic signed [VAL_W-1:0] value_out;
    logic [1:0]              status;
    logic                    last;
    logic [POS_W-1:0]        entry_count;
  } list_beat_t;

  // Keeps its own copy of the list. It turns every accepted command into the
  // beats that the block should produce, and matches strobed beats against
  // them in order.
  class list_mirror;
    logic signed [VAL_W-1:0] entries[$];
    list_beat_t              pending_beats[$];
    int                      failures;

    function new();
      failures = 0;
    endfunction

    function int held();
      return entries.size();
    endfunction

    function void push_beat(logic signed [VAL_W-1:0] v, logic [1:0] st, logic lst);
      list_beat_t b;
      b.value_out   = v;
      b.status      = st;
      b.last        = lst;
      b.entry_count = POS_W'(entries.size());
      pending_beats.push_back(b);
    endfunction

    // Note an accepted command and predict its beats.
    function void apply_command(logic [2:0] op, logic [POS_W-1:0] pos,
                                logic signed [VAL_W-1:0] val);
      int       n;
      logic [1:0] st;
      n  = entries.size();
      st = ST_OK;
      case (op)
        OP_READOUT: begin
          if (n == 0) begin
            push_beat('0, ST_EMPTY, 1'b1);
          end else begin
            for (int i = 0; i < n; i++)
              push_beat(entries[i], ST_OK, (i == n - 1));
          end
          return;
        end
        OP_INS_FRONT: begin
          if (n >= CAPACITY) st = ST_FULL;
          else entries.push_front(val);
        end
        OP_INS_END: begin
          if (n >= CAPACITY) st = ST_FULL;
          else entries.push_back(val);
        end
        OP_INS_POS: begin
          if (n >= CAPACITY) st = ST_FULL;
          else if (pos < 1 || int'(pos) > n + 1) st = ST_RANGE;
          else entries.insert(int'(pos) - 1, val);
        end
        OP_DEL_FIRST: begin
          if (n == 0) st = ST_EMPTY;
          else entries.delete(0);
        end
        OP_DEL_LAST: begin
          if (n == 0) st = ST_EMPTY;
          else entries.delete(n - 1);
        end
        OP_DEL_POS: begin
          if (n == 0) st = ST_EMPTY;
          else if (pos < 1 || int'(pos) > n) st = ST_RANGE;
          else entries.delete(int'(pos) - 1);
        end
        default: begin
        end
      endcase
      push_beat('0, st, 1'b1);
    endfunction

    // Compare one strobed beat with the oldest prediction.
    function void compare_beat(logic signed [VAL_W-1:0] v, logic [1:0] st, logic lst,
                               logic [POS_W-1:0] cnt);
      list_beat_t b;
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat: value_out %0d status %0d last %0d entry_count %0d",
               v, st, lst, cnt);
        failures++;
        return;
      end
      b = pending_beats.pop_front();
      if (v !== b.value_out) begin
        $error("value_out mismatch: expected %0d, actual %0d", b.value_out, v);
        failures++;
      end
      if (st !== b.status) begin
        $error("status mismatch: expected %0d, actual %0d", b.status, st);
        failures++;
      end
      if (lst !== b.last) begin
        $error("last mismatch: expected %0d, actual %0d", b.last, lst);
        failures++;
      end
      if (cnt !== b.entry_count) begin
        $error("entry_count mismatch: expected %0d, actual %0d", b.entry_count, cnt);
        failures++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [2:0]              opcode;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;
  logic                    strobe;
  logic signed [VAL_W-1:0] value_out;
  logic [1:0]              status;
  logic                    last;
  logic [POS_W-1:0]        entry_count;

  list_mirror mirror = new();
  int         cycles = 0;
  bit         idling_allowed = 1'b1;

  ordered_list_store #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .position   (position),
    .value      (value),
    .strobe     (strobe),
    .value_out  (value_out),
    .status     (status),
    .last       (last),
    .entry_count(entry_count)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a run that hangs anywhere ends here as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver cannot hold beats off, so every strobed beat is taken as it
  // comes. Outputs are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (!rst && strobe === 1'b1)
      mirror.compare_beat(value_out, status, last, entry_count);
  end

  // Present one command beat and hold it until the block takes it. The
  // command is taken at the first rising edge at which busy is low.
  task automatic send_command(input logic [2:0] op, input logic [POS_W-1:0] pos,
                              input logic signed [VAL_W-1:0] val);
    opcode   <= op;
    position <= pos;
    value    <= val;
    start    <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    mirror.apply_command(op, pos, val);
  endtask

  // Now and then the sender leaves a gap. Because the gap starts right after
  // acceptance, it lands on whatever the block is doing, including the middle
  // of a long readout.
  task automatic maybe_pause();
    if (idling_allowed && $urandom_range(99) < 11) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic directed_command(input logic [2:0] op, input logic [POS_W-1:0] pos,
                                  input logic signed [VAL_W-1:0] val);
    send_command(op, pos, val);
    maybe_pause();
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Position for an insert: mostly a legal slot, sometimes just outside the
  // legal range, and sometimes anything the 7-bit field can carry.
  function automatic logic [POS_W-1:0] pick_insert_pos(int n);
    int r;
    r = $urandom_range(99);
    if (r < 80) return POS_W'($urandom_range(1, n + 1));
    if (r < 85) return '0;
    if (r < 90) return POS_W'(n + 2);
    return POS_W'($urandom_range(127));
  endfunction

  function automatic logic [POS_W-1:0] pick_delete_pos(int n);
    int r;
    r = $urandom_range(99);
    if (n > 0 && r < 80) return POS_W'($urandom_range(1, n));
    if (r < 87) return '0;
    if (r < 93) return POS_W'(n + 1);
    return POS_W'($urandom_range(127));
  endfunction

  // Choose an opcode. A fill stretch is mostly inserts so that the list runs
  // up to its capacity; a drain stretch is mostly deletes so that it empties
  // and stays empty for a while; a mixed stretch keeps it wandering.
  function automatic logic [2:0] pick_opcode(int mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      0: begin
        if (r < 6)  return OP_READOUT;
        if (r < 30) return OP_INS_FRONT;
        if (r < 55) return OP_INS_END;
        if (r < 88) return OP_INS_POS;
        if (r < 91) return OP_DEL_FIRST;
        if (r < 94) return OP_DEL_LAST;
        if (r < 98) return OP_DEL_POS;
        return OP_SPARE;
      end
      1: begin
        if (r < 10) return OP_READOUT;
        if (r < 15) return OP_INS_FRONT;
        if (r < 20) return OP_INS_END;
        if (r < 25) return OP_INS_POS;
        if (r < 50) return OP_DEL_FIRST;
        if (r < 70) return OP_DEL_LAST;
        if (r < 98) return OP_DEL_POS;
        return OP_SPARE;
      end
      default: begin
        if (r < 12) return OP_READOUT;
        if (r < 26) return OP_INS_FRONT;
        if (r < 40) return OP_INS_END;
        if (r < 56) return OP_INS_POS;
        if (r < 68) return OP_DEL_FIRST;
        if (r < 80) return OP_DEL_LAST;
        if (r < 97) return OP_DEL_POS;
        return OP_SPARE;
      end
    endcase
  endfunction

  initial begin
    int                  mode_plan[8] = '{0, 1, 2, 0, 2, 1, 0, 1};
    int                  mode;
    int                  n;
    logic [2:0]          op;
    logic [POS_W-1:0]    pos;

    rst      <= 1'b1;
    start    <= 1'b0;
    opcode   <= OP_READOUT;
    position <= '0;
    value    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Everything on an empty list first: readout, each kind of
    // delete (the empty status wins over a bad position) and inserts at
    // positions that are out of range.
    directed_command(OP_READOUT,   7'd0,   '0);
    directed_command(OP_DEL_FIRST, 7'd0,   '0);
    directed_command(OP_DEL_LAST,  7'd0,   '0);
    directed_command(OP_DEL_POS,   7'd0,   '0);
    directed_command(OP_INS_POS,   7'd0,   32'sd5);
    directed_command(OP_INS_POS,   7'd2,   32'sd5);
    // Build a short list with the extreme values, using every insert, with
    // one insert at the position just past the tail.
    directed_command(OP_INS_POS,   7'd1,   32'sh7fff_ffff);
    directed_command(OP_INS_FRONT, 7'd127, 32'sh8000_0000);
    directed_command(OP_INS_END,   7'd0,   -32'sd1);
    directed_command(OP_INS_POS,   7'd4,   32'sd0);
    directed_command(OP_INS_POS,   7'd2,   32'sd1);
    directed_command(OP_READOUT,   7'd0,   '0);
    // Deletes at bad positions, then each kind of good delete.
    directed_command(OP_DEL_POS,   7'd0,   '0);
    directed_command(OP_DEL_POS,   7'd6,   '0);
    directed_command(OP_DEL_POS,   7'd127, '0);
    directed_command(OP_DEL_POS,   7'd3,   '0);
    directed_command(OP_DEL_FIRST, 7'd0,   '0);
    directed_command(OP_DEL_LAST,  7'd0,   '0);
    // The spare opcode leaves the list alone.
    directed_command(OP_SPARE,     7'd127, -32'sd1);
    directed_command(OP_READOUT,   7'd0,   '0);
    // Down to a single entry and then to nothing.
    directed_command(OP_DEL_POS,   7'd2,   '0);
    directed_command(OP_READOUT,   7'd0,   '0);
    directed_command(OP_DEL_POS,   7'd1,   '0);
    directed_command(OP_READOUT,   7'd0,   '0);

    // Random part. A long stretch in the middle runs without any gaps so that
    // commands also arrive back to back for many beats.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idling_allowed = !(i >= 150 && i < 270);
      mode = mode_plan[(i / 48) % 8];
      n    = mirror.held();
      op   = pick_opcode(mode);
      case (op)
        OP_INS_POS: pos = pick_insert_pos(n);
        OP_DEL_POS: pos = pick_delete_pos(n);
        default:    pos = POS_W'($urandom_range(127));
      endcase
      send_command(op, pos, pick_value());
      maybe_pause();
    end
    start <= 1'b0;

    // Let every predicted beat arrive, then watch a little longer for any
    // stray beat.
    while (mirror.pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mirror.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
